@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked on every clk edge, off while arst_n is low
`define AST_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// checked on every clk edge, reset included
`define AST_ALL(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AST_RST(lbl, prop)
`define AST_ALL(lbl, prop)
`endif

`endif

@@ src/pcicfg_pkg.sv @@
// ----------------------------------------------------------------------------
// pcicfg_pkg
// Types and constants for the PCI configuration port access core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcicfg_pkg;

	typedef enum logic [1:0] {
		OP_PORT_READ  = 2'd0,
		OP_PORT_WRITE = 2'd1,
		OP_LOAD       = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	localparam logic [15:0] PORT_ADDR_FIRST = 16'h0CF8;
	localparam logic [15:0] PORT_DATA_FIRST = 16'h0CFC;
	localparam logic [15:0] PORT_LAST       = 16'h0CFF;

	localparam logic [31:0] STATUS_OK  = 32'h8000_0000;
	localparam logic [31:0] STATUS_ERR = 32'hFFFF_FFFF;
	localparam logic [7:0]  BYTE_ERR   = 8'hFF;

	localparam int MASK_SLOTS  = 16;
	localparam int STORE_BYTES = 256;
	localparam logic [7:0] PROT_LAST = 8'd4;

	typedef logic [MASK_SLOTS-1:0] slot_mask_t;

endpackage

`default_nettype wire

@@ src/pcicfg_if.sv @@
// ----------------------------------------------------------------------------
// pcicfg_req_if / pcicfg_rsp_if
// Valid/ready channels for port access requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcicfg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] port;
	logic [7:0]  write_value;
	logic [3:0]  load_slot;
	logic [7:0]  load_offset;

	modport source (output valid, operation, port, write_value, load_slot, load_offset,
		input ready);
	modport sink (input valid, operation, port, write_value, load_slot, load_offset,
		output ready);
endinterface

interface pcicfg_rsp_if;
	logic       valid;
	logic       ready;
	logic       handled;
	logic [7:0] read_data;

	modport source (output valid, handled, read_data, input ready);
	modport sink (input valid, handled, read_data, output ready);
endinterface

`default_nettype wire

@@ src/pci_config_space_port_access_core.sv @@
// ----------------------------------------------------------------------------
// pci_config_space_port_access_core
// Byte-wide access to config ports 0xCF8-0xCFF over a per-slot config store.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req      in   operation, port, write_value, load_slot, load_offset
//  rsp      out  handled, read_data
//  cfg      in   cfg_we, cfg_wdata (slot_present_mask)
//
//  One request per cycle; its result is presented on the next cycle.
//  Address, status and store updates happen at the accept edge; the store
//  read uses the registered read port of the RAM, which sets the latency.
//  rsp stalls hold the result stage and the RAM read data; req.ready drops
//  only while a result waits and rsp.ready is low. No store clear at reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pci_config_space_port_access_core #(
	parameter int SLOTS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire pcicfg_pkg::slot_mask_t cfg_wdata,
	pcicfg_req_if.sink                  req,
	pcicfg_rsp_if.source                rsp
);

	import pcicfg_pkg::*;

	localparam int DEPTH = SLOTS * STORE_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	slot_mask_t  mask_q;
	logic [31:0] address_q;
	logic [31:0] status_q;

	logic        valid_s1;
	logic        handled_s1;
	logic        use_ram_s1;
	logic [7:0]  byte_s1;

	logic        accept;
	op_t         op;
	logic        is_rd, is_wr, is_load;
	logic        in_range, is_data;
	logic [1:0]  lane;
	logic [15:0] slot;
	logic        slot_good;
	logic [7:0]  offset;
	logic        ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr, store_addr;
	logic [7:0]  ram_wdata, ram_rdata;
	logic [7:0]  status_byte;
	logic        handled_d;
	logic        use_ram_d;
	logic [7:0]  byte_d;

	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 || rsp.ready;

	assign op       = op_t'(req.operation);
	assign is_rd    = (op == OP_PORT_READ);
	assign is_wr    = (op == OP_PORT_WRITE);
	assign is_load  = (op == OP_LOAD);
	assign in_range = (req.port >= PORT_ADDR_FIRST) && (req.port <= PORT_LAST);
	assign is_data  = (req.port >= PORT_DATA_FIRST);
	assign lane     = req.port[1:0];

	assign slot      = address_q[23:8];
	assign slot_good = (32'(slot) < 32'(SLOTS)) && (slot < 16'(MASK_SLOTS))
		&& mask_q[slot[3:0]];
	assign offset    = {address_q[7:2], lane};
	assign store_addr = AW'({slot, offset});

	always_comb begin
		case (lane)
			2'd0: status_byte = status_q[7:0];
			2'd1: status_byte = status_q[15:8];
			2'd2: status_byte = status_q[23:16];
			2'd3: status_byte = status_q[31:24];
			default: status_byte = status_q[7:0];
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = store_addr;
		ram_wdata = req.write_value;
		if (is_load) begin
			ram_we    = 32'(req.load_slot) < 32'(SLOTS);
			ram_waddr = AW'({req.load_slot, req.load_offset});
		end else if (is_wr && in_range && is_data) begin
			ram_we = slot_good && (offset > PROT_LAST);
		end
		ram_we = ram_we && accept;
	end

	assign ram_raddr = store_addr;
	assign ram_re    = accept && is_rd && in_range && is_data && slot_good;

	always_comb begin
		handled_d = is_load || ((is_rd || is_wr) && in_range);
		use_ram_d = 1'b0;
		byte_d    = 8'd0;
		if (is_rd && in_range) begin
			if (!is_data) begin
				byte_d = status_byte;
			end else if (slot_good) begin
				use_ram_d = 1'b1;
			end else begin
				byte_d = BYTE_ERR;
			end
		end
	end

	pcicfg_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= '0;
			status_q  <= '0;
		end else if (accept && (is_rd || is_wr) && in_range) begin
			if (!is_data) begin
				if (is_wr) begin
					for (int i = 0; i < 4; i++) begin
						if (lane == 2'(i)) begin
							address_q[i*8 +: 8] <= req.write_value;
						end
					end
				end
			end else begin
				status_q <= slot_good ? STATUS_OK : STATUS_ERR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			handled_s1 <= handled_d;
			use_ram_s1 <= use_ram_d;
			byte_s1    <= byte_d;
		end
	end

	assign rsp.valid     = valid_s1;
	assign rsp.handled   = handled_s1;
	assign rsp.read_data = use_ram_s1 ? ram_rdata : byte_s1;

	`AST_RST(a_status_codes, status_q == 32'd0 || status_q == STATUS_OK || status_q == STATUS_ERR)
	`AST_RST(a_load_handled, accept && is_load |=> valid_s1 && handled_s1)
	`AST_RST(a_ram_needs_handled, valid_s1 && use_ram_s1 |-> handled_s1)
	`AST_RST(a_unhandled_zero, valid_s1 && !handled_s1 |-> !use_ram_s1 && byte_s1 == 8'd0)
	`AST_RST(a_one_ram_access, !(ram_we && ram_re))

endmodule

`default_nettype wire

@@ src/pcicfg_ram.sv @@
// ----------------------------------------------------------------------------
// pcicfg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcicfg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_pci_config_space_port_access_core.sv @@
// ----------------------------------------------------------------------------
// tb_pci_config_space_port_access_core
// Self-checking bench for the config port access core: a queue-fed request
// driver and a result monitor compare every result with an in-bench model
// of the 0xCF8-0xCFF address/data port mechanism over several slot masks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pci_config_space_port_access_core;
	import pcicfg_pkg::*;

	localparam int SLOTS       = 16;
	localparam int STORE_SIZE  = SLOTS * STORE_BYTES;
	localparam int PHASE_REQS  = 270;
	localparam int LONG_HOLD   = 64;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		op_t         op;
		logic [15:0] port;
		logic [7:0]  wval;
		logic [3:0]  lslot;
		logic [7:0]  loff;
	} access_t;

	typedef struct packed {
		logic       handled;
		logic [7:0] rdata;
	} result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	slot_mask_t cfg_wdata;

	pcicfg_req_if req ();
	pcicfg_rsp_if rsp ();

	pci_config_space_port_access_core #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	// model of the port mechanism
	logic [31:0] cfg_addr;
	logic [31:0] cfg_status;
	slot_mask_t  cfg_mask;
	logic [7:0]  cfg_store [STORE_SIZE];

	// stimulus-side shadow, runs ahead of the model
	logic [31:0] gen_addr;
	slot_mask_t  gen_mask;
	bit          written [STORE_SIZE];

	access_t pending_q [$];
	result_t expected_q [$];
	access_t cur_acc;

	int  n_queued, n_counted, n_accepted, n_results, n_masks;
	int  n_store_reads, n_bad_slot, n_unhandled;
	int  errors, cycles, send_gap, hold;
	bit  send_idle, recv_idle;

	function automatic result_t cfgmech_step(access_t a);
		result_t     r;
		logic [1:0]  lane;
		logic [15:0] slot;
		logic [7:0]  offs;
		logic        good;
		int          idx;
		r = '0;
		lane = a.port[1:0];
		case (a.op)
			OP_LOAD: begin
				r.handled = 1'b1;
				if (a.lslot < SLOTS)
					cfg_store[int'(a.lslot) * STORE_BYTES + int'(a.loff)] = a.wval;
			end
			OP_PORT_READ, OP_PORT_WRITE: begin
				if (a.port >= PORT_ADDR_FIRST && a.port <= PORT_LAST) begin
					r.handled = 1'b1;
					if (a.port < PORT_DATA_FIRST) begin
						if (a.op == OP_PORT_READ)
							r.rdata = cfg_status[{lane, 3'b000} +: 8];
						else
							cfg_addr[{lane, 3'b000} +: 8] = a.wval;
					end else begin
						slot = cfg_addr[23:8];
						offs = {cfg_addr[7:2], lane};
						good = slot < SLOTS && slot < MASK_SLOTS && cfg_mask[slot[3:0]];
						idx = int'(slot[3:0]) * STORE_BYTES + int'(offs);
						cfg_status = good ? STATUS_OK : STATUS_ERR;
						if (!good)
							n_bad_slot++;
						if (a.op == OP_PORT_READ) begin
							if (good) begin
								r.rdata = cfg_store[idx];
								n_store_reads++;
							end else begin
								r.rdata = BYTE_ERR;
							end
						end else if (good && offs > PROT_LAST) begin
							cfg_store[idx] = a.wval;
						end
					end
				end else begin
					n_unhandled++;
				end
			end
			default: n_unhandled++;
		endcase
		return r;
	endfunction

	// queue one request; a store read of a byte never written gets a load first
	task automatic push_req(op_t op, logic [15:0] port, logic [7:0] wval,
			logic [3:0] lslot, logic [7:0] loff);
		access_t     a;
		logic [15:0] slot;
		logic [7:0]  offs;
		logic        good;
		int          idx;
		slot = gen_addr[23:8];
		offs = {gen_addr[7:2], port[1:0]};
		good = slot < SLOTS && slot < MASK_SLOTS && gen_mask[slot[3:0]];
		idx = int'(slot[3:0]) * STORE_BYTES + int'(offs);
		if (op == OP_LOAD) begin
			n_counted++;
			if (lslot < SLOTS)
				written[int'(lslot) * STORE_BYTES + int'(loff)] = 1'b1;
		end else if ((op == OP_PORT_READ || op == OP_PORT_WRITE) &&
				port >= PORT_ADDR_FIRST && port <= PORT_LAST) begin
			n_counted++;
			if (port < PORT_DATA_FIRST) begin
				if (op == OP_PORT_WRITE)
					gen_addr[{port[1:0], 3'b000} +: 8] = wval;
			end else if (good) begin
				if (op == OP_PORT_READ && !written[idx])
					push_req(OP_LOAD, 16'($urandom), 8'($urandom), slot[3:0], offs);
				if (op == OP_PORT_WRITE && offs > PROT_LAST)
					written[idx] = 1'b1;
			end
		end
		a.op = op;
		a.port = port;
		a.wval = wval;
		a.lslot = lslot;
		a.loff = loff;
		pending_q.push_back(a);
		n_queued++;
	endtask

	task automatic write_mask(slot_mask_t m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_mask = m;
		gen_mask = m;
		n_masks++;
	endtask

	task automatic wait_drain();
		while (n_accepted != n_queued || expected_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests still expected",
				cycles, expected_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		access_t nxt;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= OP_PORT_READ;
			req.port <= '0;
			req.write_value <= '0;
			req.load_slot <= '0;
			req.load_offset <= '0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_q.push_back(cfgmech_step(cur_acc));
				n_accepted++;
			end
			if (!req.valid || req.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					nxt = pending_q.pop_front();
					cur_acc = nxt;
					req.valid <= 1'b1;
					req.operation <= nxt.op;
					req.port <= nxt.port;
					req.write_value <= nxt.wval;
					req.load_slot <= nxt.lslot;
					req.load_offset <= nxt.loff;
					send_gap = send_idle ? $urandom_range(0, 10) : 0;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				n_results++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result handled=%0b read_data=%02h",
						$realtime, rsp.handled, rsp.read_data);
				end else begin
					want = expected_q.pop_front();
					if (rsp.handled !== want.handled) begin
						errors++;
						$display("%0t: handled expected %0b actual %0b",
							$realtime, want.handled, rsp.handled);
					end
					if (rsp.read_data !== want.rdata) begin
						errors++;
						$display("%0t: read_data expected %02h actual %02h",
							$realtime, want.rdata, rsp.read_data);
					end
				end
				if (n_results % 700 == 350)
					hold = LONG_HOLD;
				else
					hold = recv_idle ? $urandom_range(0, 10) : 0;
			end else if (hold != 0) begin
				hold--;
			end
			rsp.ready <= (hold == 0);
		end
	end

	initial begin
		slot_mask_t  m;
		logic [31:0] a32;
		int          r, k, n, start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.operation = OP_PORT_READ;
		req.port = '0;
		req.write_value = '0;
		req.load_slot = '0;
		req.load_offset = '0;
		rsp.ready = 1'b0;
		cfg_addr = '0;
		cfg_status = '0;
		cfg_mask = '0;
		gen_addr = '0;
		gen_mask = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: no slot present
		push_req(OP_PORT_READ, PORT_ADDR_FIRST, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_DATA_FIRST, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_ADDR_FIRST + 16'd3, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_WRITE, PORT_LAST, 8'hAA, 4'h0, 8'h00);
		wait_drain();

		write_mask(16'hFFFF);
		for (int b = 0; b < 4; b++)
			push_req(OP_PORT_WRITE, 16'(PORT_DATA_FIRST + b), 8'hE0, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_DATA_FIRST + 16'd2, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_ADDR_FIRST + 16'd3, 8'h00, 4'h0, 8'h00);
		// offset 4 is protected, offset 5 is not
		push_req(OP_PORT_WRITE, PORT_ADDR_FIRST, 8'h04, 4'h0, 8'h00);
		push_req(OP_PORT_WRITE, PORT_DATA_FIRST, 8'h5A, 4'h0, 8'h00);
		push_req(OP_PORT_WRITE, PORT_DATA_FIRST + 16'd1, 8'hA5, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_DATA_FIRST, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_DATA_FIRST + 16'd1, 8'h00, 4'h0, 8'h00);
		// last slot, last byte; low address bits are masked off
		push_req(OP_LOAD, 16'hFFFF, 8'hC3, 4'hF, 8'hFF);
		push_req(OP_PORT_WRITE, PORT_ADDR_FIRST + 16'd1, 8'h0F, 4'h0, 8'h00);
		push_req(OP_PORT_WRITE, PORT_ADDR_FIRST, 8'hFF, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_LAST, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_WRITE, PORT_LAST, 8'h3C, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_LAST, 8'h00, 4'h0, 8'h00);
		// slot beyond mask range
		push_req(OP_PORT_WRITE, PORT_ADDR_FIRST + 16'd2, 8'hFF, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_DATA_FIRST + 16'd2, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_READ, PORT_ADDR_FIRST + 16'd1, 8'h00, 4'h0, 8'h00);
		// ports just outside the window, port extremes, unused op
		push_req(OP_PORT_READ, PORT_ADDR_FIRST - 16'd1, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_WRITE, PORT_LAST + 16'd1, 8'hFF, 4'hF, 8'hFF);
		push_req(OP_PORT_READ, 16'h0000, 8'h00, 4'h0, 8'h00);
		push_req(OP_PORT_WRITE, 16'hFFFF, 8'hFF, 4'hF, 8'hFF);
		push_req(OP_NONE, PORT_DATA_FIRST, 8'hFF, 4'hF, 8'hFF);
		wait_drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: m = 16'hFFFF;
				1: m = 16'h0000;
				3: m = 16'h8001;
				5: m = 16'hFFFF;
				default: m = slot_mask_t'($urandom);
			endcase
			send_idle = (ph != 3);
			recv_idle = (ph != 3);
			write_mask(m);
			start = n_counted;
			while (n_counted - start < PHASE_REQS) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					// program the address, then a burst of data-port accesses mixed with some address-port reads
					a32 = {8'($urandom),
						($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00,
						($urandom_range(0, 9) == 0) ? 8'($urandom) :
							8'($urandom_range(0, 15)),
						8'($urandom)};
					k = $urandom_range(0, 3);
					for (int b = 0; b < 4; b++)
						if (k > 1 || k == b)
							push_req(OP_PORT_WRITE, 16'(PORT_ADDR_FIRST + b),
								a32[b*8 +: 8], 4'($urandom), 8'($urandom));
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						if ($urandom_range(0, 5) == 0)
							push_req(OP_PORT_READ,
								16'(PORT_ADDR_FIRST + $urandom_range(0, 3)),
								8'($urandom), 4'($urandom), 8'($urandom));
						else
							push_req($urandom_range(0, 1) ? OP_PORT_WRITE : OP_PORT_READ,
								16'(PORT_DATA_FIRST + $urandom_range(0, 3)),
								8'($urandom), 4'($urandom), 8'($urandom));
				end else if (r < 70) begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						push_req(OP_LOAD, 16'($urandom), 8'($urandom),
							4'($urandom), 8'($urandom));
				end else if (r < 85) begin
					push_req($urandom_range(0, 1) ? OP_PORT_WRITE : OP_PORT_READ,
						16'(PORT_ADDR_FIRST + $urandom_range(0, 3)),
						8'($urandom), 4'($urandom), 8'($urandom));
				end else begin
					push_req(op_t'($urandom_range(0, 3)),
						$urandom_range(0, 1) ? 16'($urandom) :
							16'($urandom_range(16'h0CF0, 16'h0D07)),
						8'($urandom), 4'($urandom), 8'($urandom));
				end
			end
			wait_drain();
		end

		repeat (5) @(posedge clk);
		$display("%0d requests over %0d slot masks: %0d store reads, %0d bad-slot accesses,",
			n_accepted, n_masks, n_store_reads, n_bad_slot);
		$display("%0d unhandled; gaps of 0-10 cycles both sides, long output stalls of %0d",
			n_unhandled, LONG_HOLD);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
